[hw/rtl/wpd_pkg.sv]
// Shared constants, codes and control types of the weighted pool draw unit.
package wpd_pkg;

    localparam int MAX_ENTRIES_DEF   = 16;
    localparam int WEIGHT_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int KIND_W        = 2;
    localparam int SLOT_W        = 4;
    localparam int WVAL_W        = 16;
    localparam int FRAC_W        = 16;
    localparam int INDEX_W       = 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 8;
    localparam int ENTRY_COUNT_W = 5;
    localparam int ROLL_COUNT_W  = 8;
    localparam int REMAIN_W      = 20;
    localparam int RESULT_LIMIT  = 16;
    localparam int SCAN_W        = 5;
    localparam int STEP_W        = 4;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ROLL  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROLL_COUNT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROLL_EACH_ENTRY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_WEIGHTS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ALLOW_DUPS      = 3'd4;

    typedef struct packed {
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic [ROLL_COUNT_W-1:0]  roll_count;
        logic                     roll_each_entry;
        logic                     ignore_weights;
        logic                     allow_duplicates;
    } cfg_t;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_ACCEPT,
        UOP_WRITE,
        UOP_START_SETUP,
        UOP_SUM_SCAN,
        UOP_SET_REMAIN,
        UOP_EMIT_ENUM,
        UOP_ROLL_SETUP,
        UOP_ROLL_SCAN,
        UOP_EMIT_NONE,
        UOP_EMIT_SEL
    } uop_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_NEVER,
        COND_IN_VALID,
        COND_KIND_LOAD,
        COND_KIND_START,
        COND_KIND_NOT_ROLL,
        COND_SCAN_DONE,
        COND_SCAN_STOP,
        COND_NOT_EACH,
        COND_N_ZERO,
        COND_ENUM_LAST_GO,
        COND_ROLL_REFUSE,
        COND_FOUND,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        uop_t              op;
        cond_t             cond;
        logic              hold;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic kind_load;
        logic kind_start;
        logic kind_roll;
        logic scan_done;
        logic scan_stop;
        logic each_mode;
        logic n_zero;
        logic enum_last_go;
        logic roll_refuse;
        logic found;
    } status_t;

endpackage

[hw/rtl/wpd_if.sv]
// Item and result channel interfaces of the weighted pool draw unit.
interface wpd_item_if;
    logic                       valid;
    logic                       ready;
    logic [wpd_pkg::KIND_W-1:0] kind;
    logic [wpd_pkg::SLOT_W-1:0] entry_slot;
    logic [wpd_pkg::WVAL_W-1:0] weight_value;
    logic [wpd_pkg::FRAC_W-1:0] random_fraction;

    modport source (output valid, output kind, output entry_slot, output weight_value,
                    output random_fraction, input ready);
    modport sink (input valid, input kind, input entry_slot, input weight_value,
                  input random_fraction, output ready);
endinterface

interface wpd_result_if;
    logic                        valid;
    logic                        ready;
    logic [wpd_pkg::INDEX_W-1:0] entry_index;
    logic                        found;
    logic                        last;

    modport source (output valid, output entry_index, output found, output last,
                    input ready);
    modport sink (input valid, input entry_index, input found, input last,
                  output ready);
endinterface

[hw/rtl/wpd_sequencer.sv]
// Microcode store, step counter and branch logic of the draw unit.
module wpd_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  wpd_pkg::status_t    status,
    output wpd_pkg::ctrl_word_t ctrl
);
    import wpd_pkg::*;

    localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] ST_D_LOAD    = 4'd1;
    localparam logic [STEP_W-1:0] ST_D_START   = 4'd2;
    localparam logic [STEP_W-1:0] ST_D_ROLL    = 4'd3;
    localparam logic [STEP_W-1:0] ST_R_CHECK   = 4'd4;
    localparam logic [STEP_W-1:0] ST_R_SETUP   = 4'd5;
    localparam logic [STEP_W-1:0] ST_R_SCAN    = 4'd6;
    localparam logic [STEP_W-1:0] ST_R_FOUND   = 4'd7;
    localparam logic [STEP_W-1:0] ST_EMIT_NONE = 4'd8;
    localparam logic [STEP_W-1:0] ST_EMIT_SEL  = 4'd9;
    localparam logic [STEP_W-1:0] ST_LOAD      = 4'd10;
    localparam logic [STEP_W-1:0] ST_S_SETUP   = 4'd11;
    localparam logic [STEP_W-1:0] ST_S_SUM     = 4'd12;
    localparam logic [STEP_W-1:0] ST_S_REMAIN  = 4'd13;
    localparam logic [STEP_W-1:0] ST_S_EMPTY   = 4'd14;
    localparam logic [STEP_W-1:0] ST_S_ENUM    = 4'd15;

    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '{op: UOP_NONE, cond: COND_ALWAYS, hold: 1'b0, target: ST_IDLE};
        case (step)
            ST_IDLE:      w = '{op: UOP_ACCEPT,      cond: COND_IN_VALID,
                                hold: 1'b1, target: ST_D_LOAD};
            ST_D_LOAD:    w = '{op: UOP_NONE,        cond: COND_KIND_LOAD,
                                hold: 1'b0, target: ST_LOAD};
            ST_D_START:   w = '{op: UOP_NONE,        cond: COND_KIND_START,
                                hold: 1'b0, target: ST_S_SETUP};
            ST_D_ROLL:    w = '{op: UOP_NONE,        cond: COND_KIND_NOT_ROLL,
                                hold: 1'b0, target: ST_IDLE};
            ST_R_CHECK:   w = '{op: UOP_NONE,        cond: COND_ROLL_REFUSE,
                                hold: 1'b0, target: ST_EMIT_NONE};
            ST_R_SETUP:   w = '{op: UOP_ROLL_SETUP,  cond: COND_NEVER,
                                hold: 1'b0, target: ST_IDLE};
            ST_R_SCAN:    w = '{op: UOP_ROLL_SCAN,   cond: COND_SCAN_STOP,
                                hold: 1'b1, target: ST_R_FOUND};
            ST_R_FOUND:   w = '{op: UOP_NONE,        cond: COND_FOUND,
                                hold: 1'b0, target: ST_EMIT_SEL};
            ST_EMIT_NONE: w = '{op: UOP_EMIT_NONE,   cond: COND_OUT_FREE,
                                hold: 1'b1, target: ST_IDLE};
            ST_EMIT_SEL:  w = '{op: UOP_EMIT_SEL,    cond: COND_OUT_FREE,
                                hold: 1'b1, target: ST_IDLE};
            ST_LOAD:      w = '{op: UOP_WRITE,       cond: COND_ALWAYS,
                                hold: 1'b0, target: ST_IDLE};
            ST_S_SETUP:   w = '{op: UOP_START_SETUP, cond: COND_NEVER,
                                hold: 1'b0, target: ST_IDLE};
            ST_S_SUM:     w = '{op: UOP_SUM_SCAN,    cond: COND_SCAN_DONE,
                                hold: 1'b1, target: ST_S_REMAIN};
            ST_S_REMAIN:  w = '{op: UOP_SET_REMAIN,  cond: COND_NOT_EACH,
                                hold: 1'b0, target: ST_IDLE};
            ST_S_EMPTY:   w = '{op: UOP_NONE,        cond: COND_N_ZERO,
                                hold: 1'b0, target: ST_EMIT_NONE};
            ST_S_ENUM:    w = '{op: UOP_EMIT_ENUM,   cond: COND_ENUM_LAST_GO,
                                hold: 1'b1, target: ST_IDLE};
            default:      w = '{op: UOP_NONE,        cond: COND_ALWAYS,
                                hold: 1'b0, target: ST_IDLE};
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    ctrl_word_t        word;
    logic              go;

    assign word = ucode(pc_reg);
    assign ctrl = word;

    always_comb
    begin
        case (word.cond)
            COND_ALWAYS:        go = 1'b1;
            COND_NEVER:         go = 1'b0;
            COND_IN_VALID:      go = status.in_valid;
            COND_KIND_LOAD:     go = status.kind_load;
            COND_KIND_START:    go = status.kind_start;
            COND_KIND_NOT_ROLL: go = !status.kind_roll;
            COND_SCAN_DONE:     go = status.scan_done;
            COND_SCAN_STOP:     go = status.scan_stop;
            COND_NOT_EACH:      go = !status.each_mode;
            COND_N_ZERO:        go = status.n_zero;
            COND_ENUM_LAST_GO:  go = status.enum_last_go;
            COND_ROLL_REFUSE:   go = status.roll_refuse;
            COND_FOUND:         go = status.found;
            COND_OUT_FREE:      go = status.out_free;
            default:            go = 1'b0;
        endcase

        if (go)
        begin
            pc_next = word.target;
        end
        else if (word.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[hw/rtl/wpd_datapath.sv]
// Weight memory, draw state, roll multiplier, scan accumulator and result register.
module wpd_datapath #(
    parameter int MAX_ENTRIES   = wpd_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS   = wpd_pkg::WEIGHT_BITS_DEF,
    parameter int FRACTION_BITS = wpd_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    wpd_item_if.sink            item_ch,
    wpd_result_if.source        result_ch,
    input  wpd_pkg::cfg_t       cfg,
    input  wpd_pkg::ctrl_word_t ctrl,
    output wpd_pkg::status_t    status
);
    import wpd_pkg::*;

    localparam int ADDR_W     = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LIVE_LIMIT = (MAX_ENTRIES < RESULT_LIMIT) ? MAX_ENTRIES : RESULT_LIMIT;
    localparam int ACC_W      = REMAIN_W + 1;
    localparam int SUM_W      = ((ACC_W > WEIGHT_BITS) ? ACC_W : WEIGHT_BITS) + 1;
    localparam int PROD_W     = FRAC_W + REMAIN_W;
    localparam int USED_W     = $clog2(RESULT_LIMIT);

    localparam logic [ACC_W-1:0]    ACC_MAX    = '1;
    localparam logic [REMAIN_W-1:0] REMAIN_MAX = '1;

    // accepted word
    logic [KIND_W-1:0] kind_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [WVAL_W-1:0] wval_reg;
    logic [FRAC_W-1:0] frac_reg;

    logic [WEIGHT_BITS-1:0] weight_mem [MAX_ENTRIES];
    logic [WEIGHT_BITS-1:0] ram_q_reg;

    logic [RESULT_LIMIT-1:0] used_reg,   used_next;
    logic [REMAIN_W-1:0]     remain_reg, remain_next;
    logic [ROLL_COUNT_W-1:0] rolls_reg,  rolls_next;
    logic [SCAN_W-1:0]       idx_reg,    idx_next;
    logic [ACC_W-1:0]        acc_reg,    acc_next;
    logic                    found_reg,  found_next;
    logic [PROD_W-1:0]       prod_reg;
    logic [INDEX_W-1:0]      sel_idx_reg;

    logic               ov_reg, ov_next;
    logic [INDEX_W-1:0] oidx_reg, oidx_next;
    logic               ofound_reg, ofound_next;
    logic               olast_reg, olast_next;
    logic               out_load;

    logic [SCAN_W-1:0]      live_n;
    logic [WEIGHT_BITS-1:0] w_cur;
    logic [WEIGHT_BITS-1:0] add_term;
    logic [SUM_W-1:0]       sum_wide;
    logic [ACC_W-1:0]       acc_sat;
    logic [REMAIN_W-1:0]    roll_val;
    logic [REMAIN_W-1:0]    rem_less;
    logic                   scan_done;
    logic                   skip;
    logic                   hit;
    logic                   out_free;
    logic                   enum_last;
    logic                   accept;

    assign accept = item_ch.valid && item_ch.ready;

    assign live_n    = (cfg.entry_count > SCAN_W'(LIVE_LIMIT)) ? SCAN_W'(LIVE_LIMIT)
                                                               : cfg.entry_count;
    assign w_cur     = cfg.ignore_weights ? WEIGHT_BITS'(1) : ram_q_reg;
    assign scan_done = (idx_reg == live_n);
    assign skip      = !cfg.allow_duplicates && used_reg[idx_reg[USED_W-1:0]];
    assign add_term  = skip ? '0 : w_cur;
    assign sum_wide  = SUM_W'(acc_reg) + SUM_W'(add_term);
    assign acc_sat   = (sum_wide > SUM_W'(ACC_MAX)) ? ACC_MAX : ACC_W'(sum_wide);
    assign roll_val  = REMAIN_W'(prod_reg >> FRACTION_BITS);
    assign hit       = !scan_done && !skip && (ACC_W'(roll_val) < acc_sat);
    assign rem_less  = (SUM_W'(remain_reg) > SUM_W'(w_cur))
                     ? REMAIN_W'(SUM_W'(remain_reg) - SUM_W'(w_cur)) : '0;
    assign out_free  = !ov_reg || result_ch.ready;
    assign enum_last = ((idx_reg + SCAN_W'(1)) == live_n);

    assign item_ch.ready = (ctrl.op == UOP_ACCEPT);

    assign result_ch.valid       = ov_reg;
    assign result_ch.entry_index = oidx_reg;
    assign result_ch.found       = ofound_reg;
    assign result_ch.last        = olast_reg;

    always_comb
    begin
        status.in_valid     = item_ch.valid;
        status.out_free     = out_free;
        status.kind_load    = (kind_reg == KIND_LOAD);
        status.kind_start   = (kind_reg == KIND_START);
        status.kind_roll    = (kind_reg == KIND_ROLL);
        status.scan_done    = scan_done;
        status.scan_stop    = scan_done || hit;
        status.each_mode    = cfg.roll_each_entry;
        status.n_zero       = (live_n == '0);
        status.enum_last_go = out_free && enum_last;
        status.roll_refuse  = cfg.roll_each_entry || (rolls_reg >= cfg.roll_count);
        status.found        = found_reg;
    end

    always_comb
    begin
        used_next   = used_reg;
        remain_next = remain_reg;
        rolls_next  = rolls_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        found_next  = found_reg;
        out_load    = 1'b0;
        oidx_next   = oidx_reg;
        ofound_next = ofound_reg;
        olast_next  = olast_reg;

        case (ctrl.op)
            UOP_START_SETUP:
            begin
                used_next  = '0;
                rolls_next = '0;
                acc_next   = '0;
                idx_next   = '0;
            end
            UOP_SUM_SCAN:
            begin
                if (!scan_done)
                begin
                    acc_next = acc_sat;
                    idx_next = idx_reg + SCAN_W'(1);
                end
            end
            UOP_SET_REMAIN:
            begin
                remain_next = (acc_reg > ACC_W'(REMAIN_MAX)) ? REMAIN_MAX
                                                             : REMAIN_W'(acc_reg);
                idx_next    = '0;
            end
            UOP_EMIT_ENUM:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    oidx_next   = idx_reg[INDEX_W-1:0];
                    ofound_next = 1'b1;
                    olast_next  = enum_last;
                    idx_next    = idx_reg + SCAN_W'(1);
                end
            end
            UOP_ROLL_SETUP:
            begin
                rolls_next = rolls_reg + ROLL_COUNT_W'(1);
                acc_next   = '0;
                idx_next   = '0;
                found_next = 1'b0;
            end
            UOP_ROLL_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    if (!cfg.allow_duplicates)
                    begin
                        used_next[idx_reg[USED_W-1:0]] = 1'b1;
                        remain_next = rem_less;
                    end
                end
                else if (!scan_done)
                begin
                    acc_next = acc_sat;
                    idx_next = idx_reg + SCAN_W'(1);
                end
            end
            UOP_EMIT_NONE:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    oidx_next   = '0;
                    ofound_next = 1'b0;
                    olast_next  = 1'b1;
                end
            end
            UOP_EMIT_SEL:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    oidx_next   = sel_idx_reg;
                    ofound_next = 1'b1;
                    olast_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            ov_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            remain_reg <= '0;
            rolls_reg  <= '0;
            idx_reg    <= '0;
            acc_reg    <= '0;
            found_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            remain_reg <= remain_next;
            rolls_reg  <= rolls_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            found_reg  <= found_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= item_ch.kind;
            slot_reg <= item_ch.entry_slot;
            wval_reg <= item_ch.weight_value;
            frac_reg <= item_ch.random_fraction;
        end
        if (ctrl.op == UOP_ROLL_SETUP)
        begin
            prod_reg <= PROD_W'(frac_reg) * PROD_W'(remain_reg);
        end
        if (ctrl.op == UOP_ROLL_SCAN && hit)
        begin
            sel_idx_reg <= idx_reg[INDEX_W-1:0];
        end
        if (out_load)
        begin
            oidx_reg   <= oidx_next;
            ofound_reg <= ofound_next;
            olast_reg  <= olast_next;
        end
    end

    // weight memory: one write port, one registered read port following the scan index
    always_ff @(posedge clk)
    begin
        if (ctrl.op == UOP_WRITE && (32'(slot_reg) < MAX_ENTRIES))
        begin
            weight_mem[ADDR_W'(slot_reg)] <= WEIGHT_BITS'(wval_reg);
        end
        ram_q_reg <= weight_mem[ADDR_W'(idx_next)];
    end

endmodule

[hw/rtl/weighted_pool_draw_unit.sv]
// Top level of the weighted pool draw unit: configuration registers and unit assembly.
//
// Roulette-wheel draw over a table of up to MAX_ENTRIES weights, without replacement unless
// duplicates are allowed. One word is handled at a time by a sixteen-step microcode
// sequencer; the weight memory is read one entry per cycle, so the live entry count n sets
// the time of a start or a roll, which can also wait on the result channel; a roll includes
// the 16 x 20 roll multiply. The next word is accepted while the last result still waits
// in the output register. Configuration may be written only while no word is in
// progress.
module weighted_pool_draw_unit #(
    parameter int MAX_ENTRIES   = wpd_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS   = wpd_pkg::WEIGHT_BITS_DEF,
    parameter int FRACTION_BITS = wpd_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    wpd_item_if.sink                         item_ch,
    wpd_result_if.source                     result_ch,
    input  logic                             cfg_write_en,
    input  logic [wpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import wpd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    ctrl_word_t ctrl;
    status_t    status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ENTRY_COUNT:     cfg_next.entry_count      = cfg_data[ENTRY_COUNT_W-1:0];
                REG_ROLL_COUNT:      cfg_next.roll_count       = cfg_data[ROLL_COUNT_W-1:0];
                REG_ROLL_EACH_ENTRY: cfg_next.roll_each_entry  = cfg_data[0];
                REG_IGNORE_WEIGHTS:  cfg_next.ignore_weights   = cfg_data[0];
                REG_ALLOW_DUPS:      cfg_next.allow_duplicates = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_count      <= '0;
            cfg_reg.roll_count       <= ROLL_COUNT_W'(1);
            cfg_reg.roll_each_entry  <= 1'b0;
            cfg_reg.ignore_weights   <= 1'b0;
            cfg_reg.allow_duplicates <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wpd_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    wpd_datapath #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch),
        .cfg       (cfg_reg),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the weighted pool draw unit: directed draws, then random phases.
module testbench;
    import wpd_pkg::*;

    localparam int RANDOM_WORDS  = 470;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 1_500_000;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam longint unsigned REMAIN_CAP = (64'd1 << REMAIN_W) - 64'd1;

    typedef struct packed {
        logic [INDEX_W-1:0] entry_index;
        logic               found;
        logic               last;
    } pick_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    wpd_item_if   item_ch ();
    wpd_result_if result_ch ();

    weighted_pool_draw_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_ch      (item_ch),
        .result_ch    (result_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // draw state as the unit should hold it
    logic [WVAL_W-1:0]       weight_mem [RESULT_LIMIT];
    logic [RESULT_LIMIT-1:0] used_set;
    logic [REMAIN_W-1:0]     remain;
    logic [ROLL_COUNT_W-1:0] rolls_taken;
    cfg_t                    shadow_cfg;

    pick_t pending_picks [$];
    int    mismatches;
    int    words_sent;
    int    cycles;
    bit    steady_items;
    bit    steady_results;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** weighted_pool_draw_unit: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic pick_t make_pick(int unsigned idx, logic found, logic last);
        pick_t p;
        p.entry_index = INDEX_W'(idx);
        p.found       = found;
        p.last        = last;
        return p;
    endfunction

    function automatic int unsigned live_count();
        return (shadow_cfg.entry_count > RESULT_LIMIT) ? RESULT_LIMIT : shadow_cfg.entry_count;
    endfunction

    function automatic longint unsigned weight_of(int unsigned j);
        return shadow_cfg.ignore_weights ? 64'd1 : longint'(weight_mem[j]);
    endfunction

    task automatic predict_word(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                                input logic [WVAL_W-1:0] wval, input logic [FRAC_W-1:0] frac);
        int unsigned                    n;
        longint unsigned                sum;
        longint unsigned                acc;
        longint unsigned                roll;
        longint unsigned                w;
        logic [FRAC_W+REMAIN_W-1:0]     product;
        bit                             hit;
        n = live_count();
        case (kind)
            KIND_LOAD:
                weight_mem[slot] = wval;
            KIND_START:
            begin
                used_set    = '0;
                rolls_taken = '0;
                sum         = 0;
                for (int j = 0; j < n; j++)
                begin
                    sum += weight_of(j);
                    if (sum > REMAIN_CAP)
                        sum = REMAIN_CAP;
                end
                remain = REMAIN_W'(sum);
                if (shadow_cfg.roll_each_entry)
                begin
                    if (n == 0)
                        pending_picks.push_back(make_pick(0, 1'b0, 1'b1));
                    for (int j = 0; j < n; j++)
                        pending_picks.push_back(make_pick(j, 1'b1, j == n - 1));
                end
            end
            KIND_ROLL:
            begin
                hit = 1'b0;
                if (!shadow_cfg.roll_each_entry && rolls_taken < shadow_cfg.roll_count)
                begin
                    rolls_taken = rolls_taken + 1'b1;
                    product     = frac * remain;
                    roll        = product >> FRACTION_BITS_DEF;
                    acc         = 0;
                    for (int j = 0; j < n && !hit; j++)
                    begin
                        if (shadow_cfg.allow_duplicates || !used_set[j])
                        begin
                            w = weight_of(j);
                            acc += w;
                            if (roll < acc)
                            begin
                                hit = 1'b1;
                                if (!shadow_cfg.allow_duplicates)
                                begin
                                    used_set[j] = 1'b1;
                                    remain = (remain > w) ? REMAIN_W'(remain - w) : '0;
                                end
                                pending_picks.push_back(make_pick(j, 1'b1, 1'b1));
                            end
                        end
                    end
                end
                if (!hit)
                    pending_picks.push_back(make_pick(0, 1'b0, 1'b1));
            end
            default:
                ;
        endcase
    endtask

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                             input logic [WVAL_W-1:0] wval, input logic [FRAC_W-1:0] frac);
        int gap;
        gap = pick_gap(steady_items);
        repeat (gap) @(negedge clk);
        item_ch.valid           = 1'b1;
        item_ch.kind            = kind;
        item_ch.entry_slot      = slot;
        item_ch.weight_value    = wval;
        item_ch.random_fraction = frac;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predict_word(kind, slot, wval, frac);
        if (kind != KIND_SPARE)
            words_sent++;
        @(negedge clk);
        item_ch.valid = 1'b0;
    endtask

    task automatic load_weight(input logic [SLOT_W-1:0] slot, input logic [WVAL_W-1:0] wval);
        send_word(KIND_LOAD, slot, wval, FRAC_W'($urandom));
    endtask

    task automatic start_draw();
        send_word(KIND_START, SLOT_W'($urandom), WVAL_W'($urandom), FRAC_W'($urandom));
    endtask

    task automatic roll_once(input logic [FRAC_W-1:0] frac);
        send_word(KIND_ROLL, SLOT_W'($urandom), WVAL_W'($urandom), frac);
    endtask

    // wait until every result is in and the unit has finished any silent word
    task automatic settle();
        while (pending_picks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = value;
        @(negedge clk);
        cfg_write_en = 1'b0;
        case (idx)
            REG_ENTRY_COUNT:     shadow_cfg.entry_count      = value[ENTRY_COUNT_W-1:0];
            REG_ROLL_COUNT:      shadow_cfg.roll_count       = value;
            REG_ROLL_EACH_ENTRY: shadow_cfg.roll_each_entry  = value[0];
            REG_IGNORE_WEIGHTS:  shadow_cfg.ignore_weights   = value[0];
            REG_ALLOW_DUPS:      shadow_cfg.allow_duplicates = value[0];
            default:             ;
        endcase
    endtask

    task automatic set_config(input logic [ENTRY_COUNT_W-1:0] count,
                              input logic [ROLL_COUNT_W-1:0] limit,
                              input logic each, input logic ign, input logic dups);
        write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(count));
        write_reg(REG_ROLL_COUNT, limit);
        write_reg(REG_ROLL_EACH_ENTRY, CFG_DATA_W'(each));
        write_reg(REG_IGNORE_WEIGHTS, CFG_DATA_W'(ign));
        write_reg(REG_ALLOW_DUPS, CFG_DATA_W'(dups));
    endtask

    function automatic logic [WVAL_W-1:0] random_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return WVAL_W'($urandom_range(1, 15));
            3:       return WVAL_W'($urandom_range(1, 255));
            default: return WVAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] random_fraction();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    // defaults after reset: no live entries, one roll per draw
    task automatic test_empty_pool();
        start_draw();
        roll_once('1);
        roll_once('0);
        send_word(KIND_SPARE, '1, '1, '1);
    endtask

    task automatic test_table_load();
        load_weight(4'd0, 16'hFFFF);
        load_weight(4'd1, 16'h0000);
        load_weight(4'd2, 16'h0001);
        load_weight(4'd3, 16'h8000);
    endtask

    // strict less-than: a roll equal to the running sum moves on to the next entry
    task automatic test_weighted_rolls();
        set_config(5'd4, 8'd255, 1'b0, 1'b0, 1'b0);
        start_draw();
        roll_once(16'h0000);
        roll_once(16'h0002);
        roll_once(16'hFFFF);
        roll_once(16'h8000);
    endtask

    task automatic test_each_entry_mode();
        set_config(5'd0, 8'd1, 1'b1, 1'b0, 1'b0);
        start_draw();
        write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(4));
        start_draw();
        roll_once(16'h4000);
    endtask

    task automatic test_draw_options();
        set_config(5'd4, 8'd2, 1'b0, 1'b1, 1'b1);
        start_draw();
        roll_once('1);
        roll_once('1);
        roll_once('1);
        // weight removal saturating at zero once weights count again
        write_reg(REG_ALLOW_DUPS, CFG_DATA_W'(0));
        start_draw();
        write_reg(REG_IGNORE_WEIGHTS, CFG_DATA_W'(0));
        roll_once('0);
        roll_once('0);
        write_reg(REG_ROLL_COUNT, CFG_DATA_W'(0));
        start_draw();
        roll_once(16'h1234);
    endtask

    task automatic run_random_phase();
        logic [ENTRY_COUNT_W-1:0] count;
        logic [ROLL_COUNT_W-1:0]  limit;
        int                       draws;
        int                       rolls;
        case ($urandom_range(0, 7))
            0:       count = 5'd0;
            1:       count = 5'd16;
            2:       count = 5'd31;
            3:       count = 5'd1;
            default: count = ENTRY_COUNT_W'($urandom_range(2, 16));
        endcase
        case ($urandom_range(0, 5))
            0:       limit = 8'd0;
            1:       limit = 8'd255;
            2:       limit = 8'd1;
            default: limit = ROLL_COUNT_W'($urandom_range(2, 20));
        endcase
        set_config(count, limit, $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 2) == 0);
        steady_items = ($urandom_range(0, 4) == 0);
        draws = $urandom_range(1, 3);
        repeat (draws)
        begin
            if ($urandom_range(0, 3) == 0)
                load_weight(SLOT_W'($urandom), random_weight());
            start_draw();
            rolls = $urandom_range(1, 20);
            repeat (rolls)
            begin
                case ($urandom_range(0, 19))
                    0:       send_word(KIND_SPARE, SLOT_W'($urandom), WVAL_W'($urandom),
                                       FRAC_W'($urandom));
                    1:       load_weight(SLOT_W'($urandom), random_weight());
                    2:       start_draw();
                    default: roll_once(random_fraction());
                endcase
            end
        end
    endtask

    task automatic test_random_draws();
        int stop_at;
        stop_at = words_sent + RANDOM_WORDS;
        for (int s = 4; s < RESULT_LIMIT; s++)
            load_weight(SLOT_W'(s), random_weight());
        while (words_sent < stop_at)
            run_random_phase();
    endtask

    // result side: random stalls, with stretches of none
    initial
    begin
        int stall;
        int span;
        stall = 0;
        span  = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                steady_results = ($urandom_range(0, 3) == 0);
                span = $urandom_range(50, 300);
            end
            span--;
            if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                if (!steady_results && $urandom_range(0, 99) < 30)
                    stall = pick_gap(1'b0);
            end
        end
    end

    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("unexpected result word: entry_index %0d found %0b last %0b",
                       result_ch.entry_index, result_ch.found, result_ch.last);
                mismatches++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (result_ch.entry_index !== want.entry_index)
                begin
                    $error("entry_index: expected %0d, actual %0d", want.entry_index,
                           result_ch.entry_index);
                    mismatches++;
                end
                if (result_ch.found !== want.found)
                begin
                    $error("found: expected %0b, actual %0b", want.found, result_ch.found);
                    mismatches++;
                end
                if (result_ch.last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, result_ch.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n                   = 1'b0;
        cfg_write_en            = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        item_ch.valid           = 1'b0;
        item_ch.kind            = KIND_LOAD;
        item_ch.entry_slot      = '0;
        item_ch.weight_value    = '0;
        item_ch.random_fraction = '0;
        mismatches              = 0;
        words_sent              = 0;
        steady_items            = 1'b0;
        used_set                = '0;
        remain                  = '0;
        rolls_taken             = '0;
        shadow_cfg              = '0;
        shadow_cfg.roll_count   = 8'd1;
        for (int j = 0; j < RESULT_LIMIT; j++)
            weight_mem[j] = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_pool();
        test_table_load();
        test_weighted_rolls();
        test_each_entry_mode();
        test_draw_options();
        test_random_draws();
        settle();

        if (mismatches == 0 && pending_picks.size() == 0)
            $display("** weighted_pool_draw_unit: PASSED **");
        else
            $display("** weighted_pool_draw_unit: FAILED **");
        $finish;
    end

endmodule

[files.f]
hw/rtl/wpd_pkg.sv
hw/rtl/wpd_if.sv
hw/rtl/wpd_sequencer.sv
hw/rtl/wpd_datapath.sv
hw/rtl/weighted_pool_draw_unit.sv
sim/testbench.sv
